[rtl/core/accumulator_stack_cpu_step_macros.svh]
// ----------------------------------------------------------------------------
// accumulator_stack_cpu_step_macros.svh
// Assertion macros shared by the accumulator stack CPU files.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_STACK_CPU_STEP_MACROS_SVH
`define ACCUMULATOR_STACK_CPU_STEP_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define ACSC_CHK_IMP(label, cname, rname, ante, cons, msg) \
  label: assert property (@(posedge cname) disable iff (rname) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under a synchronous reset.
`define ACSC_CHK_NXT(label, cname, rname, ante, cons, msg) \
  label: assert property (@(posedge cname) disable iff (rname) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/acsc_pkg.sv]
// ----------------------------------------------------------------------------
// acsc_pkg
// Types, constants and helpers of the accumulator stack CPU.
// ----------------------------------------------------------------------------
package acsc_pkg;

  // Word memory is 2**MEM_AW words; every address wraps to MEM_AW bits.
  localparam int MEM_AW    = 12;
  localparam int MEM_WORDS = 1 << MEM_AW;
  localparam int WORD_W    = 32;

  typedef logic [MEM_AW-1:0] maddr_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_HALT  = 2'd1,
    ST_BADOP = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    OP_LDC  = 8'd0,
    OP_ADC  = 8'd1,
    OP_LDL  = 8'd2,
    OP_STL  = 8'd3,
    OP_LDNL = 8'd4,
    OP_STNL = 8'd5,
    OP_ADD  = 8'd6,
    OP_SUB  = 8'd7,
    OP_SHL  = 8'd8,
    OP_SHR  = 8'd9,
    OP_ADJ  = 8'd10,
    OP_A2SP = 8'd11,
    OP_SP2A = 8'd12,
    OP_CALL = 8'd13,
    OP_RET  = 8'd14,
    OP_BRZ  = 8'd15,
    OP_BRLZ = 8'd16,
    OP_BR   = 8'd17,
    OP_HALT = 8'd18
  } opcode_t;

  typedef enum logic [1:0] {
    MK_NONE,
    MK_LOAD,
    MK_STORE
  } mem_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] pc;
    logic [WORD_W-1:0] sp;
    status_t           status;
  } regs_t;

  typedef struct packed {
    regs_t             nxt;
    mem_kind_t         kind;
    maddr_t            addr;
    logic [WORD_W-1:0] wdata;
    logic [7:0]        opcode;
  } exec_out_t;

  function automatic maddr_t to_addr(input logic [WORD_W-1:0] v);
    return v[MEM_AW-1:0];
  endfunction

endpackage

[rtl/core/acsc_req_if.sv]
// ----------------------------------------------------------------------------
// acsc_req_if
// Request channel: one memory load or one instruction step.
// ----------------------------------------------------------------------------
interface acsc_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic        [11:0] load_address;
  logic signed [31:0] load_data;

  modport source (output valid, action, load_address, load_data, input ready);
  modport sink   (input valid, action, load_address, load_data, output ready);
endinterface

[rtl/core/acsc_rsp_if.sv]
// ----------------------------------------------------------------------------
// acsc_rsp_if
// Response channel: register file and status after each request.
// ----------------------------------------------------------------------------
interface acsc_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] reg_a_out;
  logic signed [31:0] reg_b_out;
  logic signed [31:0] pc_out;
  logic signed [31:0] sp_out;
  logic        [7:0]  executed_opcode;

  modport source (output valid, status, reg_a_out, reg_b_out, pc_out, sp_out,
                  executed_opcode, input ready);
  modport sink   (input valid, status, reg_a_out, reg_b_out, pc_out, sp_out,
                  executed_opcode, output ready);
endinterface

[rtl/core/accumulator_stack_cpu_step.sv]
// ----------------------------------------------------------------------------
// accumulator_stack_cpu_step
// Accumulator/stack CPU that loads one memory word or runs one instruction
// per request, reporting the register file after each request.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+---------------------------------------------
//  req     | in  | valid/ready | action, load_address, load_data
//  rsp     | out | valid/ready | status, reg_a_out, reg_b_out, pc_out,
//          |     |             | sp_out, executed_opcode
//
//  A request's word fetch is issued on acceptance; E executes the word that
//  the RAM registers. Load requests and plain steps sustain one request per
//  cycle; steps that store or load a data word hold off the next request,
//  since the data access takes the word memory after the fetch. The result
//  register holds one finished request; while it waits unaccepted, the pipe
//  and req both stall. Reset (rst, synchronous) clears A, B, PC, SP and status;
//  memory content is undefined until written.
// ----------------------------------------------------------------------------
`include "accumulator_stack_cpu_step_macros.svh"

module accumulator_stack_cpu_step import acsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  acsc_req_if.sink    req,
  acsc_rsp_if.source  rsp
);

  // Architectural registers.
  regs_t             regs;

  // Execute stage (E) and memory-load stage (M).
  logic              e_valid;
  logic              e_step;
  logic              m_valid;
  logic [7:0]        m_opcode;

  exec_out_t         x;
  logic              adv;
  logic              accept;
  logic              e_run;
  logic              e_ld;
  logic              e_st;
  logic              produce;
  regs_t             res_regs;
  logic [7:0]        res_opc;
  maddr_t            fetch_addr;

  logic              ram_wr_en;
  maddr_t            ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  maddr_t            ram_rd_addr;
  logic [WORD_W-1:0] ram_rdata;

  acsc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata)
  );

  // Decode the fetched word against the current registers.
  acsc_exec u_exec (
    .cur  (regs),
    .word (ram_rdata),
    .res  (x)
  );

  // Advance the pipe unless a finished result still waits.
  assign adv   = !rsp.valid || rsp.ready;
  assign e_run = e_valid && e_step;
  assign e_ld  = e_run && (x.kind == MK_LOAD);
  assign e_st  = e_run && (x.kind == MK_STORE);

  // Hold new requests while E owns a memory port.
  assign req.ready = adv && !(e_ld || e_st);
  assign accept    = req.valid && req.ready;

  // Forward the PC of the step in E so the next fetch follows it directly.
  assign fetch_addr = e_run ? to_addr(x.nxt.pc) : to_addr(regs.pc);

  assign ram_wr_en   = (accept && req.action) || (adv && e_st);
  assign ram_wr_addr = e_st ? x.addr : to_addr(WORD_W'(req.load_address));
  assign ram_wr_data = e_st ? x.wdata : req.load_data;
  assign ram_rd_en   = (accept && !req.action) || (adv && e_ld);
  assign ram_rd_addr = e_ld ? x.addr : fetch_addr;

  // Result of whichever stage finishes this cycle.
  assign produce = m_valid || (e_valid && !e_ld);

  always_comb begin
    res_regs = regs;
    res_opc  = '0;
    if (m_valid) begin
      res_regs.a = ram_rdata;
      res_opc    = m_opcode;
    end else if (e_run) begin
      res_regs = x.nxt;
      res_opc  = x.opcode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs      <= '0;
      e_valid   <= 1'b0;
      e_step    <= 1'b0;
      m_valid   <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (adv) begin
      e_valid   <= accept;
      e_step    <= !req.action;
      m_valid   <= e_ld;
      rsp.valid <= produce;
      if (e_run) begin
        regs <= x.nxt;
      end
      if (m_valid) begin
        regs.a <= ram_rdata;
      end
    end
  end

  // Payload registers: opcode of a pending load and the result slot.
  always_ff @(posedge clk) begin
    if (adv && e_ld) begin
      m_opcode <= x.opcode;
    end
    if (adv && produce) begin
      rsp.status          <= 2'(res_regs.status);
      rsp.reg_a_out       <= res_regs.a;
      rsp.reg_b_out       <= res_regs.b;
      rsp.pc_out          <= res_regs.pc;
      rsp.sp_out          <= res_regs.sp;
      rsp.executed_opcode <= res_opc;
    end
  end

  `ACSC_CHK_IMP(a_port_exclusive, clk, rst, ram_wr_en, !ram_rd_en, "memory read and write collide")
  `ACSC_CHK_IMP(a_stage_exclusive, clk, rst, m_valid, !e_valid, "E and M stages both occupied")
  `ACSC_CHK_NXT(a_load_follow, clk, rst, adv && e_ld, m_valid && !e_valid, "load did not reach M")
  `ACSC_CHK_NXT(a_stop_sticky, clk, rst, regs.status != ST_RUN, regs.status == $past(regs.status), "stopped CPU changed status")

endmodule

[rtl/core/acsc_ram.sv]
// ----------------------------------------------------------------------------
// acsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/acsc_exec.sv]
// ----------------------------------------------------------------------------
// acsc_exec
// Decode one fetched word and compute next registers and memory access.
// ----------------------------------------------------------------------------
module acsc_exec import acsc_pkg::*; (
  input  regs_t             cur,
  input  logic [WORD_W-1:0] word,
  output exec_out_t         res
);

  opcode_t           opc;
  logic [WORD_W-1:0] opd;
  logic [WORD_W-1:0] pc_inc;
  logic [WORD_W-1:0] pc_rel;

  assign opc    = opcode_t'(word[7:0]);
  assign opd    = {{8{word[WORD_W-1]}}, word[WORD_W-1:8]};
  assign pc_inc = cur.pc + 32'd1;
  assign pc_rel = pc_inc + opd;

  always_comb begin
    res        = '0;
    res.nxt    = cur;
    res.kind   = MK_NONE;
    res.wdata  = cur.a;
    if (cur.status == ST_RUN) begin
      res.nxt.pc = pc_inc;
      res.opcode = word[7:0];
      case (opc)
        OP_LDC: begin
          res.nxt.b = cur.a;
          res.nxt.a = opd;
        end
        OP_ADC: res.nxt.a = cur.a + opd;
        OP_LDL: begin
          res.nxt.b = cur.a;
          res.kind  = MK_LOAD;
          res.addr  = to_addr(cur.sp + opd);
        end
        OP_STL: begin
          res.kind  = MK_STORE;
          res.addr  = to_addr(cur.sp + opd);
          res.wdata = cur.a;
          res.nxt.a = cur.b;
        end
        OP_LDNL: begin
          res.kind = MK_LOAD;
          res.addr = to_addr(cur.a + opd);
        end
        OP_STNL: begin
          res.kind  = MK_STORE;
          res.addr  = to_addr(cur.a + opd);
          res.wdata = cur.b;
        end
        OP_ADD: res.nxt.a = cur.b + cur.a;
        OP_SUB: res.nxt.a = cur.b - cur.a;
        OP_SHL: res.nxt.a = (|cur.a[WORD_W-1:5]) ? '0 : (cur.b << cur.a[4:0]);
        OP_SHR: begin
          // Out-of-range amounts fill with the sign of B.
          if (|cur.a[WORD_W-1:5]) begin
            res.nxt.a = {WORD_W{cur.b[WORD_W-1]}};
          end else begin
            res.nxt.a = WORD_W'($signed(cur.b) >>> cur.a[4:0]);
          end
        end
        OP_ADJ: res.nxt.sp = cur.sp + opd;
        OP_A2SP: begin
          res.nxt.sp = cur.a;
          res.nxt.a  = cur.b;
        end
        OP_SP2A: begin
          res.nxt.b = cur.a;
          res.nxt.a = cur.sp;
        end
        OP_CALL: begin
          res.nxt.b  = cur.a;
          res.nxt.a  = pc_inc;
          res.nxt.pc = pc_rel;
        end
        OP_RET: begin
          res.nxt.pc = cur.a;
          res.nxt.a  = cur.b;
        end
        OP_BRZ: begin
          if (cur.a == '0) begin
            res.nxt.pc = pc_rel;
          end
        end
        OP_BRLZ: begin
          if (cur.a[WORD_W-1]) begin
            res.nxt.pc = pc_rel;
          end
        end
        OP_BR:   res.nxt.pc = pc_rel;
        OP_HALT: res.nxt.status = ST_HALT;
        default: res.nxt.status = ST_BADOP;
      endcase
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the accumulator stack CPU. It builds programs in
// the word memory through load requests, single-steps them, and checks the
// register file and status after every request against a cycle-free mirror
// of the processor kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb import acsc_pkg::*; ();

  // Random stimulus length and the point from which both sides stop idling.
  localparam int RANDOM_REQS   = 900;
  localparam int QUIET_FROM    = 800;
  localparam int PAUSE_AT      = 450;
  localparam int LONG_HOLD_AT  = 300;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam int TAIL_REQS     = 12;

  typedef struct packed {
    status_t     status;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc;
    logic [31:0] sp;
    logic [7:0]  opcode;
  } cpu_result_t;

  typedef struct {
    maddr_t      addr;
    logic [31:0] data;
  } mem_load_t;

  // Mirror of the processor plus the queue of register files still owed.
  class cpu_shadow;
    logic [31:0] mem_word [MEM_WORDS];
    bit          mem_set  [MEM_WORDS];
    logic [31:0] reg_a;
    logic [31:0] reg_b;
    logic [31:0] reg_pc;
    logic [31:0] reg_sp;
    status_t     run_state;
    cpu_result_t results_q[$];
    int          errors;
    int          requests;

    function new();
      reg_a     = '0;
      reg_b     = '0;
      reg_pc    = '0;
      reg_sp    = '0;
      run_state = ST_RUN;
      errors    = 0;
      requests  = 0;
      foreach (mem_set[i]) mem_set[i] = 1'b0;
    endfunction

    function int pending();
      return results_q.size();
    endfunction

    function void store_word(logic [31:0] ea, logic [31:0] data);
      mem_word[ea[MEM_AW-1:0]] = data;
      mem_set[ea[MEM_AW-1:0]]  = 1'b1;
    endfunction

    // Address that an instruction word would read from, if it reads at all.
    function bit read_target(logic [31:0] word, output maddr_t addr);
      logic [31:0] operand;
      logic [31:0] ea;
      operand = {{8{word[31]}}, word[31:8]};
      addr    = '0;
      case (word[7:0])
        OP_LDL:  ea = reg_sp + operand;
        OP_LDNL: ea = reg_a + operand;
        default: return 1'b0;
      endcase
      addr = ea[MEM_AW-1:0];
      return 1'b1;
    endfunction

    function void note_request(bit act, maddr_t addr, logic [31:0] data);
      logic [31:0] word;
      logic [31:0] operand;
      logic [31:0] ea;
      logic [7:0]  opc;
      cpu_result_t r;
      opc = '0;
      requests++;
      if (act) begin
        store_word({{(32-MEM_AW){1'b0}}, addr}, data);
      end else if (run_state == ST_RUN) begin
        word    = mem_word[reg_pc[MEM_AW-1:0]];
        reg_pc  = reg_pc + 32'd1;
        opc     = word[7:0];
        operand = {{8{word[31]}}, word[31:8]};
        case (opc)
          OP_LDC: begin
            reg_b = reg_a;
            reg_a = operand;
          end
          OP_ADC:  reg_a = reg_a + operand;
          OP_LDL: begin
            ea    = reg_sp + operand;
            reg_b = reg_a;
            reg_a = mem_word[ea[MEM_AW-1:0]];
          end
          OP_STL: begin
            store_word(reg_sp + operand, reg_a);
            reg_a = reg_b;
          end
          OP_LDNL: begin
            ea    = reg_a + operand;
            reg_a = mem_word[ea[MEM_AW-1:0]];
          end
          OP_STNL: store_word(reg_a + operand, reg_b);
          OP_ADD:  reg_a = reg_b + reg_a;
          OP_SUB:  reg_a = reg_b - reg_a;
          OP_SHL: begin
            if (reg_a > 32'd31) reg_a = '0;
            else reg_a = reg_b << reg_a[4:0];
          end
          OP_SHR: begin
            if (reg_a > 32'd31) reg_a = {32{reg_b[31]}};
            else reg_a = $signed(reg_b) >>> reg_a[4:0];
          end
          OP_ADJ:  reg_sp = reg_sp + operand;
          OP_A2SP: begin
            reg_sp = reg_a;
            reg_a  = reg_b;
          end
          OP_SP2A: begin
            reg_b = reg_a;
            reg_a = reg_sp;
          end
          OP_CALL: begin
            reg_b  = reg_a;
            reg_a  = reg_pc;
            reg_pc = reg_pc + operand;
          end
          OP_RET: begin
            reg_pc = reg_a;
            reg_a  = reg_b;
          end
          OP_BRZ: begin
            if (reg_a == '0) reg_pc = reg_pc + operand;
          end
          OP_BRLZ: begin
            if (reg_a[31]) reg_pc = reg_pc + operand;
          end
          OP_BR:   reg_pc = reg_pc + operand;
          OP_HALT: run_state = ST_HALT;
          default: run_state = ST_BADOP;
        endcase
      end
      r.status = run_state;
      r.a      = reg_a;
      r.b      = reg_b;
      r.pc     = reg_pc;
      r.sp     = reg_sp;
      r.opcode = opc;
      results_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(cpu_result_t got);
      cpu_result_t want;
      if (results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d pc %h",
                 $time, got.status, got.pc);
        errors++;
        return;
      end
      want = results_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("reg_a_out", want.a, got.a);
      compare_field("reg_b_out", want.b, got.b);
      compare_field("pc_out", want.pc, got.pc);
      compare_field("sp_out", want.sp, got.sp);
      compare_field("executed_opcode", want.opcode, got.opcode);
    endfunction
  endclass

  logic clk;
  logic rst;

  acsc_req_if req();
  acsc_rsp_if rsp();

  accumulator_stack_cpu_step u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  cpu_shadow sb = new();

  // Shared stimulus shaping: idle rates per side, and a flag that turns
  // idling off on both sides for the closing stretch.
  bit quiet;
  int send_idle_pct;
  int take_idle_pct;

  // Instruction at PC has been placed or chosen for reuse; step next.
  bit code_ready;

  mem_load_t   boot_loads[$];
  logic [31:0] boot_words[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset at the start, once.
  initial begin
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: a correct run ends far earlier than this.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] encode(logic [7:0] op, logic [23:0] operand);
    return {operand, op};
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // Draw a well-formed instruction: any opcode short of halt, with operands
  // biased toward small values, shift amounts near the 0..31 edge and the
  // ends of the 24-bit range.
  function automatic logic [31:0] random_word();
    logic [7:0]  op;
    logic [23:0] operand;
    int          small_val;
    if ($urandom_range(0, 4) == 0) op = OP_LDC;
    else op = 8'($urandom_range(OP_LDC, OP_BR));
    small_val = $urandom_range(0, 32) - 16;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: operand = small_val[23:0];
      5:             operand = 24'($urandom_range(0, 33));
      6, 7:          operand = 24'($urandom());
      8: begin
        case ($urandom_range(0, 3))
          0:       operand = 24'h7FFFFF;
          1:       operand = 24'h800000;
          2:       operand = 24'hFFFFFF;
          default: operand = 24'h000000;
        endcase
      end
      default:       operand = 24'($urandom_range(0, MEM_WORDS - 1));
    endcase
    return encode(op, operand);
  endfunction

  // Choose the next request from the mirror's state. Keep every fetch and
  // every data read on a written word: place code at PC when needed, fill a
  // read target before stepping, and overwrite anything at PC that would
  // stop the processor early.
  task automatic next_request(output bit act, output maddr_t addr,
                              output logic [31:0] data);
    maddr_t      pc_addr;
    maddr_t      tgt;
    logic [31:0] word;
    pc_addr = sb.reg_pc[MEM_AW-1:0];
    word    = sb.mem_word[pc_addr];
    act     = 1'b1;
    addr    = maddr_t'($urandom());
    data    = $urandom();
    if (boot_loads.size() != 0) begin
      addr = boot_loads[0].addr;
      data = boot_loads[0].data;
      boot_loads.pop_front();
    end else if (!code_ready && boot_words.size() == 0 && $urandom_range(0, 15) == 0) begin
      // stray write anywhere; keeps address and data bits moving
    end else if (!code_ready) begin
      code_ready = sb.mem_set[pc_addr] && word[7:0] < OP_HALT &&
                   boot_words.size() == 0 && $urandom_range(0, 1) == 1;
      if (!code_ready) begin
        addr = pc_addr;
        if (boot_words.size() != 0) data = boot_words.pop_front();
        else data = random_word();
        code_ready = 1'b1;
      end else begin
        act = 1'b0;
        code_ready = 1'b0;
        if (sb.read_target(word, tgt) && !sb.mem_set[tgt]) begin
          act = 1'b1;
          addr = tgt;
          code_ready = 1'b1;
        end
      end
    end else if (sb.read_target(word, tgt) && !sb.mem_set[tgt]) begin
      addr = tgt;
    end else begin
      act = 1'b0;
      code_ready = 1'b0;
    end
  endtask

  // Offer one request, optionally after an idle burst, and hold it until
  // the block takes it.
  task automatic send_request(bit act, maddr_t addr, logic [31:0] data);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.action       <= act;
    req.load_address <= addr;
    req.load_data    <= data;
    do @(posedge clk); while (!req.ready);
    sb.note_request(act, addr, data);
  endtask

  // Response side: check every accepted result, then decide ready for the
  // next cycle. Once, after enough requests, hold off for a long stretch so
  // the block backs up and stalls its input.
  initial begin : result_sink
    int          hold;
    int          cycle;
    bit          long_done;
    cpu_result_t got;
    hold          = 0;
    cycle         = 0;
    long_done     = 1'b0;
    take_idle_pct = 0;
    rsp.ready    <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got.status = status_t'(rsp.status);
        got.a      = rsp.reg_a_out;
        got.b      = rsp.reg_b_out;
        got.pc     = rsp.pc_out;
        got.sp     = rsp.sp_out;
        got.opcode = rsp.executed_opcode;
        sb.check_response(got);
      end
      if (cycle % 64 == 0) take_idle_pct = pick_idle_pct();
      cycle++;
      if (hold > 0) begin
        hold--;
      end else if (!long_done && sb.requests >= LONG_HOLD_AT) begin
        hold      = LONG_HOLD;
        long_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < take_idle_pct) begin
        hold = $urandom_range(1, 14);
      end
      rsp.ready <= (hold == 0);
    end
  end

  // Request side: directed program first, then random programs, then a
  // single stop. Status is sticky until reset and reset comes only once, so
  // each run ends on either halt or an unknown opcode, picked at random.
  initial begin : request_source
    bit          act;
    maddr_t      addr;
    logic [31:0] data;
    logic [7:0]  stop_op;
    int          random_sent;
    req.valid        <= 1'b0;
    req.action       <= 1'b0;
    req.load_address <= '0;
    req.load_data    <= '0;
    quiet         = 1'b0;
    code_ready    = 1'b0;
    send_idle_pct = 0;
    random_sent   = 0;

    // Field extremes on plain memory writes.
    boot_loads.push_back('{maddr_t'(MEM_WORDS - 1), 32'h8000_0000});
    boot_loads.push_back('{maddr_t'(0), 32'h7FFF_FFFF});
    boot_loads.push_back('{maddr_t'(12'hAAA), 32'hFFFF_FFFF});
    boot_loads.push_back('{maddr_t'(12'h555), 32'h0000_0000});

    // Directed program: every opcode short of halt, operand extremes, shifts
    // out of range on both sides and with negative B, a negative SP so data
    // addresses wrap, and taken and untaken branches.
    boot_words = '{
      encode(OP_LDC,  24'h7FFFFF), encode(OP_LDC,  24'h800000),
      encode(OP_ADC,  24'hFFFFFF), encode(OP_ADD,  24'h000000),
      encode(OP_SUB,  24'h000000), encode(OP_LDC,  24'd40),
      encode(OP_SHL,  24'h000000), encode(OP_LDC,  24'hFFFFFB),
      encode(OP_LDC,  24'hFFFFFF), encode(OP_SHR,  24'h000000),
      encode(OP_LDC,  24'd4),      encode(OP_SHL,  24'h000000),
      encode(OP_SP2A, 24'h000000), encode(OP_ADJ,  24'hFFFFFF),
      encode(OP_STL,  24'h000000), encode(OP_LDL,  24'h000000),
      encode(OP_A2SP, 24'h000000), encode(OP_LDNL, 24'd1),
      encode(OP_STNL, 24'd2),      encode(OP_LDC,  24'h000000),
      encode(OP_BRZ,  24'd3),      encode(OP_BRLZ, 24'd2),
      encode(OP_CALL, 24'd5),      encode(OP_RET,  24'h000000),
      encode(OP_BR,   24'hFFFFF0)
    };

    @(posedge clk iff !rst);

    while (boot_loads.size() != 0 || boot_words.size() != 0) begin
      next_request(act, addr, data);
      send_request(act, addr, data);
    end

    while (random_sent < RANDOM_REQS) begin
      if (random_sent % 40 == 0) send_idle_pct = pick_idle_pct();
      if (random_sent == QUIET_FROM) quiet = 1'b1;
      // Drain fully once mid-run before offering more.
      if (random_sent == PAUSE_AT) begin
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      next_request(act, addr, data);
      send_request(act, addr, data);
      random_sent++;
    end

    // Stop the processor, then keep stepping and writing while stopped.
    if ($urandom_range(0, 1) == 1) stop_op = OP_HALT;
    else stop_op = 8'($urandom_range(OP_HALT + 1, 8'hFF));
    send_request(1'b1, sb.reg_pc[MEM_AW-1:0], encode(stop_op, 24'($urandom())));
    send_request(1'b0, maddr_t'($urandom()), $urandom());
    repeat (TAIL_REQS) begin
      send_request(1'($urandom_range(0, 1)), maddr_t'($urandom()), $urandom());
    end

    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Allow a few more cycles so a stray extra result would be caught.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/acsc_pkg.sv
rtl/core/acsc_req_if.sv
rtl/core/acsc_rsp_if.sv
rtl/core/acsc_ram.sv
rtl/core/acsc_exec.sv
rtl/core/accumulator_stack_cpu_step.sv
test/tb.sv
